[rtl/fen_pkg.sv]
// fen_pkg: shared types, character codes and decode helpers of the fen position parser
`timescale 1ns / 1ps

package fen_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_1     = 8'h31;
    localparam logic [7:0] CH_8     = 8'h38;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_H  = 8'h68;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_UP_N  = 8'h4E;
    localparam logic [7:0] CH_UP_B  = 8'h42;
    localparam logic [7:0] CH_UP_R  = 8'h52;
    localparam logic [7:0] CH_UP_Q  = 8'h51;
    localparam logic [7:0] CH_UP_K  = 8'h4B;
    localparam logic [7:0] CH_LO_Q  = 8'h71;
    localparam logic [7:0] CH_LO_K  = 8'h6B;
    localparam logic [7:0] CH_LO_W  = 8'h77;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // field numbers of the text
    localparam logic [2:0] FLD_PLACE  = 3'd0;
    localparam logic [2:0] FLD_SIDE   = 3'd1;
    localparam logic [2:0] FLD_CASTLE = 3'd2;
    localparam logic [2:0] FLD_PASS   = 3'd3;
    localparam logic [2:0] FLD_REST   = 3'd4;

    // piece codes
    localparam logic [2:0] PC_PAWN   = 3'd0;
    localparam logic [2:0] PC_KNIGHT = 3'd1;
    localparam logic [2:0] PC_BISHOP = 3'd2;
    localparam logic [2:0] PC_ROOK   = 3'd3;
    localparam logic [2:0] PC_QUEEN  = 3'd4;
    localparam logic [2:0] PC_KING   = 3'd5;
    localparam logic [2:0] PC_BAD    = 3'd6;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_PIECE    = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [1:0] ERR_PASSANT  = 2'd3;

    // result kinds
    localparam logic KIND_PLACE   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [6:0] SQ_FULL    = 7'd64;
    localparam logic [6:0] NO_PASSANT = 7'd64;

    // one result item
    typedef struct packed {
        logic       kind;
        logic [5:0] square;
        logic [2:0] piece;
        logic       color;
        logic       white_to_move;
        logic       castle_white_king;
        logic       castle_white_queen;
        logic       castle_black_king;
        logic       castle_black_queen;
        logic [6:0] passant_square;
        logic [1:0] error_code;
        logic       last_of_run;
    } result_t;

    // whitespace: space, tab, lf, vt, ff, cr
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // piece letter of either case to piece code, bad letters give PC_BAD
    function automatic logic [2:0] piece_of(input logic [7:0] c);
        logic [7:0] u;
        logic [2:0] p;
        u = (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFFSET : c;
        case (u)
            CH_UP_P: p = PC_PAWN;
            CH_UP_N: p = PC_KNIGHT;
            CH_UP_B: p = PC_BISHOP;
            CH_UP_R: p = PC_ROOK;
            CH_UP_Q: p = PC_QUEEN;
            CH_UP_K: p = PC_KING;
            default: p = PC_BAD;
        endcase
        return p;
    endfunction

endpackage

[rtl/fen_position_parser.sv]
// fen_position_parser: character-serial fen text parser with a four-entry result queue
`timescale 1ns / 1ps

// Takes one FEN character per cycle while in_stall is low. Each accepted
// character updates the parse state in the same cycle and writes its results
// (a piece placement, an end-of-text summary, or both) into a four-entry
// result queue, so a result is registered in the queue before it is offered.
// in_stall is raised while the queue has fewer than two free entries; with a
// consumer that never stalls, a character is taken every cycle, and the input
// only stalls once characters giving both a placement and a summary, each
// adding two results, have filled the queue to three entries. After a summary
// the parser starts over for the next text.
module fen_position_parser (
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       is_last,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [5:0] square,
    output logic [2:0] piece,
    output logic       color,
    output logic       white_to_move,
    output logic       castle_white_king,
    output logic       castle_white_queen,
    output logic       castle_black_king,
    output logic       castle_black_queen,
    output logic [6:0] passant_square,
    output logic [1:0] error_code,
    output logic       last_of_run
);

    // parse state
    logic [2:0] field_index_reg, field_index_next;
    logic       in_gap_reg, in_gap_next;
    logic [6:0] square_count_reg, square_count_next;
    logic [1:0] field_length_reg, field_length_next;
    logic       side_white_reg, side_white_next;
    logic [3:0] castle_flags_reg, castle_flags_next;
    logic [7:0] passant_file_reg, passant_file_next;
    logic [7:0] passant_rank_reg, passant_rank_next;
    logic       passant_dash_reg, passant_dash_next;
    logic [1:0] error_state_reg, error_state_next;

    // result queue
    fen_pkg::result_t fifo_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    logic             in_xfer;
    logic             out_xfer;
    logic             emit;
    logic [2:0]       piece_code;
    logic             pass_ok;
    logic [6:0]       pass_sq;
    logic [1:0]       err_final;
    logic [1:0]       push_count;
    fen_pkg::result_t place_rec;
    fen_pkg::result_t summary_rec;
    fen_pkg::result_t first_rec;
    fen_pkg::result_t head_rec;

    assign in_stall = (count_reg > 3'd2);
    assign in_xfer  = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_xfer  = out_valid && !out_stall;

    assign piece_code = fen_pkg::piece_of(char_code);

    // character decode and state update
    always_comb
    begin
        field_index_next  = field_index_reg;
        in_gap_next       = in_gap_reg;
        square_count_next = square_count_reg;
        field_length_next = field_length_reg;
        side_white_next   = side_white_reg;
        castle_flags_next = castle_flags_reg;
        passant_file_next = passant_file_reg;
        passant_rank_next = passant_rank_reg;
        passant_dash_next = passant_dash_reg;
        error_state_next  = error_state_reg;
        emit              = 1'b0;

        if (fen_pkg::is_blank(char_code))
        begin
            if (!in_gap_reg)
            begin
                in_gap_next = 1'b1;
                if (field_index_reg < fen_pkg::FLD_PASS)
                begin
                    field_index_next  = field_index_reg + 3'd1;
                    field_length_next = 2'd0;
                end
                else if (field_index_reg == fen_pkg::FLD_PASS)
                begin
                    // en-passant length is kept for the summary
                    field_index_next = fen_pkg::FLD_REST;
                end
            end
        end
        else
        begin
            in_gap_next = 1'b0;
            case (field_index_reg)
                fen_pkg::FLD_PLACE:
                begin
                    if (error_state_reg == fen_pkg::ERR_NONE && char_code != fen_pkg::CH_SLASH)
                    begin
                        if (char_code >= fen_pkg::CH_0 && char_code <= fen_pkg::CH_9)
                        begin
                            // skip count, saturating at a full board
                            square_count_next = square_count_reg
                                                + 7'(char_code - fen_pkg::CH_0);
                            if (square_count_next > fen_pkg::SQ_FULL)
                                square_count_next = fen_pkg::SQ_FULL;
                        end
                        else if (piece_code == fen_pkg::PC_BAD)
                            error_state_next = fen_pkg::ERR_PIECE;
                        else if (square_count_reg >= fen_pkg::SQ_FULL)
                            error_state_next = fen_pkg::ERR_OVERFLOW;
                        else
                        begin
                            emit              = 1'b1;
                            square_count_next = square_count_reg + 7'd1;
                        end
                    end
                end
                fen_pkg::FLD_SIDE:
                begin
                    side_white_next = (field_length_reg == 2'd0)
                                      && (char_code == fen_pkg::CH_LO_W);
                    if (field_length_reg != 2'd3)
                        field_length_next = field_length_reg + 2'd1;
                end
                fen_pkg::FLD_CASTLE:
                begin
                    if (char_code == fen_pkg::CH_UP_K)
                        castle_flags_next[0] = 1'b1;
                    else if (char_code == fen_pkg::CH_UP_Q)
                        castle_flags_next[1] = 1'b1;
                    else if (char_code == fen_pkg::CH_LO_K)
                        castle_flags_next[2] = 1'b1;
                    else if (char_code == fen_pkg::CH_LO_Q)
                        castle_flags_next[3] = 1'b1;
                end
                fen_pkg::FLD_PASS:
                begin
                    if (field_length_reg == 2'd0)
                    begin
                        passant_file_next = char_code;
                        passant_dash_next = (char_code == fen_pkg::CH_DASH);
                    end
                    else if (field_length_reg == 2'd1)
                        passant_rank_next = char_code;
                    if (field_length_reg != 2'd3)
                        field_length_next = field_length_reg + 2'd1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // en-passant check on the state after this character
    always_comb
    begin
        pass_ok = 1'b0;
        pass_sq = fen_pkg::NO_PASSANT;
        if (field_index_next >= fen_pkg::FLD_PASS)
        begin
            if (field_length_next == 2'd1 && passant_dash_next)
                pass_ok = 1'b1;
            else if (field_length_next == 2'd2 && !passant_dash_next
                     && passant_file_next >= fen_pkg::CH_LO_A
                     && passant_file_next <= fen_pkg::CH_LO_H
                     && passant_rank_next >= fen_pkg::CH_1
                     && passant_rank_next <= fen_pkg::CH_8)
            begin
                pass_ok = 1'b1;
                pass_sq = {1'b0, 3'(fen_pkg::CH_8 - passant_rank_next),
                           3'(passant_file_next - fen_pkg::CH_LO_A)};
            end
        end
        err_final = (error_state_next == fen_pkg::ERR_NONE && !pass_ok)
                    ? fen_pkg::ERR_PASSANT : error_state_next;
    end

    // result records
    always_comb
    begin
        place_rec             = '0;
        place_rec.kind        = fen_pkg::KIND_PLACE;
        place_rec.square      = square_count_reg[5:0];
        place_rec.piece       = piece_code;
        place_rec.color       = !(char_code >= fen_pkg::CH_UP_A && char_code <= fen_pkg::CH_UP_Z);
        place_rec.last_of_run = !is_last;

        summary_rec                    = '0;
        summary_rec.kind               = fen_pkg::KIND_SUMMARY;
        summary_rec.white_to_move      = side_white_next;
        summary_rec.castle_white_king  = castle_flags_next[0];
        summary_rec.castle_white_queen = castle_flags_next[1];
        summary_rec.castle_black_king  = castle_flags_next[2];
        summary_rec.castle_black_queen = castle_flags_next[3];
        summary_rec.passant_square     = pass_sq;
        summary_rec.error_code         = err_final;
        summary_rec.last_of_run        = 1'b1;

        first_rec  = emit ? place_rec : summary_rec;
        push_count = {1'b0, emit} + {1'b0, is_last};
    end

    // queue pointer update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_xfer)
        begin
            wr_ptr_next = wr_ptr_reg + push_count;
            count_next  = count_next + {1'b0, push_count};
        end
        if (out_xfer)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
            count_next  = count_next - 3'd1;
        end
    end

    // control and parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_index_reg  <= fen_pkg::FLD_PLACE;
            in_gap_reg       <= 1'b1;
            square_count_reg <= '0;
            field_length_reg <= '0;
            side_white_reg   <= 1'b0;
            castle_flags_reg <= '0;
            passant_file_reg <= '0;
            passant_rank_reg <= '0;
            passant_dash_reg <= 1'b0;
            error_state_reg  <= fen_pkg::ERR_NONE;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (in_xfer)
            begin
                if (is_last)
                begin
                    // end of text: start over for the next one
                    field_index_reg  <= fen_pkg::FLD_PLACE;
                    in_gap_reg       <= 1'b1;
                    square_count_reg <= '0;
                    field_length_reg <= '0;
                    side_white_reg   <= 1'b0;
                    castle_flags_reg <= '0;
                    passant_file_reg <= '0;
                    passant_rank_reg <= '0;
                    passant_dash_reg <= 1'b0;
                    error_state_reg  <= fen_pkg::ERR_NONE;
                end
                else
                begin
                    field_index_reg  <= field_index_next;
                    in_gap_reg       <= in_gap_next;
                    square_count_reg <= square_count_next;
                    field_length_reg <= field_length_next;
                    side_white_reg   <= side_white_next;
                    castle_flags_reg <= castle_flags_next;
                    passant_file_reg <= passant_file_next;
                    passant_rank_reg <= passant_rank_next;
                    passant_dash_reg <= passant_dash_next;
                    error_state_reg  <= error_state_next;
                end
            end
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (push_count != 2'd0)
                fifo_reg[wr_ptr_reg] <= first_rec;
            if (push_count == 2'd2)
                fifo_reg[wr_ptr_reg + 2'd1] <= summary_rec;
        end
    end

    // head of queue drives the output transfer
    assign head_rec           = fifo_reg[rd_ptr_reg];
    assign kind               = head_rec.kind;
    assign square             = head_rec.square;
    assign piece              = head_rec.piece;
    assign color              = head_rec.color;
    assign white_to_move      = head_rec.white_to_move;
    assign castle_white_king  = head_rec.castle_white_king;
    assign castle_white_queen = head_rec.castle_white_queen;
    assign castle_black_king  = head_rec.castle_black_king;
    assign castle_black_queen = head_rec.castle_black_queen;
    assign passant_square     = head_rec.passant_square;
    assign error_code         = head_rec.error_code;
    assign last_of_run        = head_rec.last_of_run;

endmodule

[tb/fen_position_parser_test.sv]
// fen_position_parser_test: self-checking testbench of the fen position parser
`timescale 1ns / 1ps

// tracks the parse of the character stream and holds the results still owed by the block
class fen_tracker;
    fen_pkg::result_t due_records[$];
    int unsigned      fails;

    // parse state
    logic [2:0] fld;
    logic       gap;
    int         sq_count;
    logic [1:0] flen;
    logic       side_white;
    logic [3:0] castle;
    logic [7:0] ep_file;
    logic [7:0] ep_rank;
    logic       ep_dash;
    logic [1:0] err;

    function new();
        fails = 0;
        clear();
    endfunction

    // start of a new text
    function void clear();
        fld        = fen_pkg::FLD_PLACE;
        gap        = 1'b1;
        sq_count   = 0;
        flen       = 2'd0;
        side_white = 1'b0;
        castle     = 4'd0;
        ep_file    = 8'd0;
        ep_rank    = 8'd0;
        ep_dash    = 1'b0;
        err        = fen_pkg::ERR_NONE;
    endfunction

    // the first error of a text is the one reported
    function void flag_error(logic [1:0] code);
        if (err == fen_pkg::ERR_NONE)
            err = code;
    endfunction

    // one accepted character: update the parse and queue what it yields
    function void note_char(logic [7:0] c, logic last);
        fen_pkg::result_t rec;
        fen_pkg::result_t sum;
        logic             placed;
        logic             found;
        logic [7:0]       up;
        logic [2:0]       p;
        logic             ok;
        int               ep;
        rec    = '0;
        placed = 1'b0;
        if (c == fen_pkg::CH_SPACE || (c >= fen_pkg::CH_TAB && c <= fen_pkg::CH_CR))
        begin
            // a blank run closes the current field
            if (!gap)
            begin
                gap = 1'b1;
                if (fld < fen_pkg::FLD_PASS)
                begin
                    fld  = fld + 3'd1;
                    flen = 2'd0;
                end
                else if (fld == fen_pkg::FLD_PASS)
                    fld = fen_pkg::FLD_REST;
            end
        end
        else
        begin
            gap = 1'b0;
            case (fld)
                fen_pkg::FLD_PLACE:
                begin
                    if (err == fen_pkg::ERR_NONE && c != fen_pkg::CH_SLASH)
                    begin
                        if (c >= fen_pkg::CH_0 && c <= fen_pkg::CH_9)
                        begin
                            // empty squares, count saturates at a full board
                            sq_count = sq_count + int'(c - fen_pkg::CH_0);
                            if (sq_count > int'(fen_pkg::SQ_FULL))
                                sq_count = int'(fen_pkg::SQ_FULL);
                        end
                        else
                        begin
                            up    = (c >= fen_pkg::CH_LO_A && c <= fen_pkg::CH_LO_Z)
                                    ? c - fen_pkg::CASE_OFFSET : c;
                            found = 1'b1;
                            p     = fen_pkg::PC_PAWN;
                            case (up)
                                fen_pkg::CH_UP_P: p = fen_pkg::PC_PAWN;
                                fen_pkg::CH_UP_N: p = fen_pkg::PC_KNIGHT;
                                fen_pkg::CH_UP_B: p = fen_pkg::PC_BISHOP;
                                fen_pkg::CH_UP_R: p = fen_pkg::PC_ROOK;
                                fen_pkg::CH_UP_Q: p = fen_pkg::PC_QUEEN;
                                fen_pkg::CH_UP_K: p = fen_pkg::PC_KING;
                                default: found = 1'b0;
                            endcase
                            if (!found)
                                flag_error(fen_pkg::ERR_PIECE);
                            else if (sq_count >= int'(fen_pkg::SQ_FULL))
                                flag_error(fen_pkg::ERR_OVERFLOW);
                            else
                            begin
                                rec.kind   = fen_pkg::KIND_PLACE;
                                rec.square = sq_count[5:0];
                                rec.piece  = p;
                                rec.color  = (c >= fen_pkg::CH_UP_A && c <= fen_pkg::CH_UP_Z)
                                             ? 1'b0 : 1'b1;
                                placed     = 1'b1;
                                sq_count++;
                            end
                        end
                    end
                end
                fen_pkg::FLD_SIDE:
                begin
                    side_white = (flen == 2'd0 && c == fen_pkg::CH_LO_W);
                    if (flen != 2'd3)
                        flen = flen + 2'd1;
                end
                fen_pkg::FLD_CASTLE:
                begin
                    case (c)
                        fen_pkg::CH_UP_K: castle[0] = 1'b1;
                        fen_pkg::CH_UP_Q: castle[1] = 1'b1;
                        fen_pkg::CH_LO_K: castle[2] = 1'b1;
                        fen_pkg::CH_LO_Q: castle[3] = 1'b1;
                        default: ;
                    endcase
                end
                fen_pkg::FLD_PASS:
                begin
                    if (flen == 2'd0)
                    begin
                        ep_file = c;
                        ep_dash = (c == fen_pkg::CH_DASH);
                    end
                    else if (flen == 2'd1)
                        ep_rank = c;
                    if (flen != 2'd3)
                        flen = flen + 2'd1;
                end
                default: ;
            endcase
        end

        if (placed)
        begin
            rec.last_of_run = !last;
            due_records.push_back(rec);
        end

        // end of text: summary, then a fresh parse
        if (last)
        begin
            ep = int'(fen_pkg::NO_PASSANT);
            ok = 1'b0;
            if (fld >= fen_pkg::FLD_PASS)
            begin
                if (flen == 2'd1 && ep_dash)
                    ok = 1'b1;
                else if (flen == 2'd2 && !ep_dash
                         && ep_file >= fen_pkg::CH_LO_A && ep_file <= fen_pkg::CH_LO_H
                         && ep_rank >= fen_pkg::CH_1 && ep_rank <= fen_pkg::CH_8)
                begin
                    ok = 1'b1;
                    ep = (int'(fen_pkg::CH_8) - int'(ep_rank)) * 8
                         + (int'(ep_file) - int'(fen_pkg::CH_LO_A));
                end
            end
            if (!ok)
                flag_error(fen_pkg::ERR_PASSANT);
            sum                    = '0;
            sum.kind               = fen_pkg::KIND_SUMMARY;
            sum.white_to_move      = side_white;
            sum.castle_white_king  = castle[0];
            sum.castle_white_queen = castle[1];
            sum.castle_black_king  = castle[2];
            sum.castle_black_queen = castle[3];
            sum.passant_square     = ep[6:0];
            sum.error_code         = err;
            sum.last_of_run        = 1'b1;
            due_records.push_back(sum);
            clear();
        end
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            fails++;
        end
    endfunction

    // one result transfer against the oldest owed result
    function void check_record(fen_pkg::result_t got);
        fen_pkg::result_t want;
        if (due_records.size() == 0)
        begin
            $error("result transfer with nothing owed: kind %0d square %0d",
                   got.kind, got.square);
            fails++;
            return;
        end
        want = due_records.pop_front();
        compare_field("kind", 8'(want.kind), 8'(got.kind));
        compare_field("square", 8'(want.square), 8'(got.square));
        compare_field("piece", 8'(want.piece), 8'(got.piece));
        compare_field("color", 8'(want.color), 8'(got.color));
        compare_field("white_to_move", 8'(want.white_to_move), 8'(got.white_to_move));
        compare_field("castle_white_king", 8'(want.castle_white_king),
                      8'(got.castle_white_king));
        compare_field("castle_white_queen", 8'(want.castle_white_queen),
                      8'(got.castle_white_queen));
        compare_field("castle_black_king", 8'(want.castle_black_king),
                      8'(got.castle_black_king));
        compare_field("castle_black_queen", 8'(want.castle_black_queen),
                      8'(got.castle_black_queen));
        compare_field("passant_square", 8'(want.passant_square), 8'(got.passant_square));
        compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
        compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
    endfunction
endclass

module fen_position_parser_test;

    localparam int ITEMS       = 1800;
    localparam int CALM_ITEMS  = 150;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 2000;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'd0;
    logic       is_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [5:0] square;
    logic [2:0] piece;
    logic       color;
    logic       white_to_move;
    logic       castle_white_king;
    logic       castle_white_queen;
    logic       castle_black_king;
    logic       castle_black_queen;
    logic [6:0] passant_square;
    logic [1:0] error_code;
    logic       last_of_run;

    fen_tracker tracker;
    int         sent        = 0;
    int         tx_odds     = 1;
    int         rx_odds     = 1;
    int         quiet_count = 0;

    fen_position_parser dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .char_code          (char_code),
        .is_last            (is_last),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .kind               (kind),
        .square             (square),
        .piece              (piece),
        .color              (color),
        .white_to_move      (white_to_move),
        .castle_white_king  (castle_white_king),
        .castle_white_queen (castle_white_queen),
        .castle_black_king  (castle_black_king),
        .castle_black_queen (castle_black_queen),
        .passant_square     (passant_square),
        .error_code         (error_code),
        .last_of_run        (last_of_run)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // one character transfer, with an optional idle burst ahead of it
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap_len;
        if (tx_odds != 0 && sent < ITEMS - CALM_ITEMS && $urandom_range(1, 12) <= tx_odds)
        begin
            in_valid <= 1'b0;
            gap_len = $urandom_range(1, 16);
            repeat (gap_len) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        is_last   <= last;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_char(c, last);
        sent++;
        if ($urandom_range(0, 63) == 0)
            tx_odds = $urandom_range(0, 3);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    // a run of one to three blanks, mostly spaces
    function automatic void add_blanks(ref logic [7:0] t[$]);
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (n)
        begin
            if ($urandom_range(0, 2) != 0)
                t.push_back(fen_pkg::CH_SPACE);
            else
                t.push_back(8'(fen_pkg::CH_TAB + $urandom_range(0, 4)));
        end
    endfunction

    // one fen text: mostly well formed with random content, some noise and truncation
    function automatic void compose_text(ref logic [7:0] t[$]);
        int         rows;
        int         filled;
        int         pick;
        int         d;
        int         n;
        int         keep;
        logic [7:0] ch;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
            begin
                ch = 8'($urandom_range(0, 255));
                t.push_back(ch);
            end
            return;
        end
        if ($urandom_range(0, 5) == 0)
            add_blanks(t);

        // placement rows
        rows = ($urandom_range(0, 1) == 0) ? 8 : $urandom_range(1, 10);
        for (int r = 0; r < rows; r++)
        begin
            if (r != 0)
                t.push_back(fen_pkg::CH_SLASH);
            filled = 0;
            while (filled < 8)
            begin
                pick = $urandom_range(0, 39);
                if (pick == 0)
                begin
                    ch = 8'($urandom_range(0, 255));
                    t.push_back(ch);
                    filled++;
                end
                else if (pick < 20)
                begin
                    d = (pick == 1) ? $urandom_range(0, 9) : $urandom_range(1, 8 - filled);
                    t.push_back(8'(fen_pkg::CH_0 + d));
                    filled += (d == 0) ? 1 : d;
                end
                else
                begin
                    case ($urandom_range(0, 5))
                        0: ch = fen_pkg::CH_UP_P;
                        1: ch = fen_pkg::CH_UP_N;
                        2: ch = fen_pkg::CH_UP_B;
                        3: ch = fen_pkg::CH_UP_R;
                        4: ch = fen_pkg::CH_UP_Q;
                        default: ch = fen_pkg::CH_UP_K;
                    endcase
                    if ($urandom_range(0, 1) != 0)
                        ch = ch + fen_pkg::CASE_OFFSET;
                    t.push_back(ch);
                    filled++;
                end
            end
        end

        // side to move
        add_blanks(t);
        pick = $urandom_range(0, 9);
        if (pick < 4)
            t.push_back(fen_pkg::CH_LO_W);
        else if (pick < 8)
            t.push_back("b");
        else
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 2))
                    0: ch = fen_pkg::CH_LO_W;
                    1: ch = "b";
                    default: ch = 8'(fen_pkg::CH_LO_A + $urandom_range(0, 25));
                endcase
                t.push_back(ch);
            end
        end

        // castling rights
        add_blanks(t);
        n = t.size();
        if ($urandom_range(0, 4) != 0)
        begin
            if ($urandom_range(0, 1) != 0)
                t.push_back(fen_pkg::CH_UP_K);
            if ($urandom_range(0, 1) != 0)
                t.push_back(fen_pkg::CH_UP_Q);
            if ($urandom_range(0, 1) != 0)
                t.push_back(fen_pkg::CH_LO_K);
            if ($urandom_range(0, 1) != 0)
                t.push_back(fen_pkg::CH_LO_Q);
            if ($urandom_range(0, 7) == 0)
                t.push_back(8'(fen_pkg::CH_UP_A + $urandom_range(0, 25)));
        end
        if (t.size() == n)
            t.push_back(fen_pkg::CH_DASH);

        // en passant
        if ($urandom_range(0, 11) != 0)
        begin
            add_blanks(t);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                t.push_back(fen_pkg::CH_DASH);
            else if (pick < 8)
            begin
                t.push_back(8'(fen_pkg::CH_LO_A + $urandom_range(0, 7)));
                t.push_back(8'(fen_pkg::CH_1 + $urandom_range(0, 7)));
            end
            else
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: ch = 8'(fen_pkg::CH_LO_A + $urandom_range(0, 9));
                        1: ch = 8'(fen_pkg::CH_0 + $urandom_range(0, 9));
                        2: ch = fen_pkg::CH_DASH;
                        default: ch = 8'($urandom_range(0, 255));
                    endcase
                    t.push_back(ch);
                end
            end
        end

        // move counters and trailing blanks, ignored by the block
        if ($urandom_range(0, 2) == 0)
        begin
            add_blanks(t);
            t.push_back(fen_pkg::CH_0);
            add_blanks(t);
            t.push_back(fen_pkg::CH_1);
        end
        if ($urandom_range(0, 5) == 0)
            add_blanks(t);

        // broken text: cut short anywhere
        if ($urandom_range(0, 7) == 0)
        begin
            keep = $urandom_range(1, t.size());
            while (t.size() > keep)
                void'(t.pop_back());
        end
    endfunction

    // stimulus
    initial
    begin
        logic [7:0] text[$];
        tracker = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: leading blanks, both cases, zero and nine digits, corner squares,
        // overflow, bad letters at the code extremes, placement together with summary
        send_text("\t bR0/9q w Kk a8");
        send_text("99999999N");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        send_text("p");
        send_text("7K w Qq h1");

        while (sent < ITEMS)
        begin
            text.delete();
            compose_text(text);
            foreach (text[k])
                send_char(text[k], k == text.size() - 1);
        end
        in_valid <= 1'b0;

        // drain, then allow for late extra results
        while (tracker.due_records.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (tracker.fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // result side stall: one long hold-off, random bursts, calm at the end
    initial
    begin : receiver
        int  burst;
        bit  held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_odds != 0 && sent < ITEMS - CALM_ITEMS
                     && $urandom_range(1, 12) <= rx_odds)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(1, 16);
                repeat (burst) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            if ($urandom_range(0, 127) == 0)
                rx_odds = $urandom_range(0, 3);
        end
    end

    // result transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_record({kind, square, piece, color, white_to_move,
                                  castle_white_king, castle_white_queen,
                                  castle_black_king, castle_black_queen,
                                  passant_square, error_code, last_of_run});
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_count = 0;
            else
            begin
                quiet_count++;
                if (quiet_count >= QUIET_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

endmodule

[sim.f]
rtl/fen_pkg.sv
rtl/fen_position_parser.sv
tb/fen_position_parser_test.sv
